// File: rtl/srce_pkg.sv
// Shared types, constants and codes of the sparse row cell encoder.
package srce_pkg;

    localparam int DEF_PHRASE_ROWS = 64;
    localparam int EFFECT_COLUMNS  = 4;
    localparam int FX_PORTS        = 4;
    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 12;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_NOTE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_EFFECT = 1'd1;

    localparam logic [7:0] MASK_NOTE = 8'h80;
    localparam logic [7:0] MASK_INST = 8'h40;
    localparam logic [7:0] MASK_VOL  = 8'h20;
    localparam logic [7:0] VOL_BITS  = 8'h7F;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Output slot order of one row: each bit of a pending vector is one slot.
    localparam int NUM_SLOTS = 14;
    localparam int SLOT_W    = 4;
    localparam logic [SLOT_W-1:0] SLOT_SKIP = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_MASK = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_NOTE = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_INST = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_VOL  = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_FX0  = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_END  = 4'd13;

    typedef logic [NUM_SLOTS-1:0] t_pend;

    typedef struct packed {
        t_pend                         pend;
        logic                          end_empty;
        logic [BYTE_W-1:0]             skip;
        logic [BYTE_W-1:0]             mask;
        logic [BYTE_W-1:0]             note;
        logic [BYTE_W-1:0]             inst;
        logic [BYTE_W-1:0]             vol;
        logic [FX_PORTS-1:0][BYTE_W-1:0] code;
        logic [FX_PORTS-1:0][BYTE_W-1:0] arg;
    } t_job;

endpackage

// File: rtl/srce_row_if.sv
// Input channel: one pattern row per word.
interface srce_row_if;
    logic       valid;
    logic       ready;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect_code_0;
    logic [7:0] effect_arg_0;
    logic [7:0] effect_code_1;
    logic [7:0] effect_arg_1;
    logic [7:0] effect_code_2;
    logic [7:0] effect_arg_2;
    logic [7:0] effect_code_3;
    logic [7:0] effect_arg_3;

    modport source (
        output valid, note, instrument, volume,
               effect_code_0, effect_arg_0, effect_code_1, effect_arg_1,
               effect_code_2, effect_arg_2, effect_code_3, effect_arg_3,
        input  ready
    );
    modport sink (
        input  valid, note, instrument, volume,
               effect_code_0, effect_arg_0, effect_code_1, effect_arg_1,
               effect_code_2, effect_arg_2, effect_code_3, effect_arg_3,
        output ready
    );
endinterface

// File: rtl/srce_res_if.sv
// Output channel: one encoded byte or phrase end marker per word.
interface srce_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  out_byte;
    logic [11:0] byte_count;
    logic        last_of_row;

    modport source (
        output valid, item_kind, out_byte, byte_count, last_of_row,
        input  ready
    );
    modport sink (
        input  valid, item_kind, out_byte, byte_count, last_of_row,
        output ready
    );
endinterface

// File: rtl/srce_front.sv
// Front end: config registers, row classification, skip and row counters.
module srce_front #(
    parameter int PHRASE_ROWS = srce_pkg::DEF_PHRASE_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srce_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srce_pkg::BYTE_W-1:0]      i_cfg_data,
    srce_row_if.sink                         i_row,
    input  logic                             i_full,
    output logic                             o_push,
    output srce_pkg::t_job                   o_job
);
    import srce_pkg::*;

    localparam int ROW_W = (PHRASE_ROWS > 1) ? $clog2(PHRASE_ROWS) : 1;

    logic [BYTE_W-1:0] r_empty_note, r_empty_fx;
    logic [BYTE_W-1:0] r_skip, n_skip;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_any, n_any;

    logic              accept;
    logic              row_end;
    logic              written;
    logic [BYTE_W-1:0] mask;
    t_pend             pend;
    logic [FX_PORTS-1:0][BYTE_W-1:0] code, arg;

    assign code = {i_row.effect_code_3, i_row.effect_code_2,
                   i_row.effect_code_1, i_row.effect_code_0};
    assign arg  = {i_row.effect_arg_3, i_row.effect_arg_2,
                   i_row.effect_arg_1, i_row.effect_arg_0};

    assign i_row.ready = !i_full;
    assign accept      = i_row.valid && !i_full;
    assign row_end     = (r_row == ROW_W'(PHRASE_ROWS - 1));

    always_comb begin
        mask = '0;
        if (i_row.note != r_empty_note) mask = mask | MASK_NOTE;
        if (i_row.instrument != '0)     mask = mask | MASK_INST;
        if ((i_row.volume & VOL_BITS) != '0) mask = mask | MASK_VOL;
        for (int c = 0; c < EFFECT_COLUMNS; c++) begin
            if (code[c] != r_empty_fx) mask[4-c] = 1'b1;
        end
    end

    assign written = (mask != '0);

    always_comb begin
        pend = '0;
        pend[SLOT_SKIP] = written;
        pend[SLOT_MASK] = written;
        pend[SLOT_NOTE] = mask[7];
        pend[SLOT_INST] = mask[6];
        pend[SLOT_VOL]  = mask[5];
        for (int c = 0; c < FX_PORTS; c++) begin
            pend[int'(SLOT_FX0) + 2*c]     = mask[4-c];
            pend[int'(SLOT_FX0) + 2*c + 1] = mask[4-c];
        end
        pend[SLOT_END] = row_end;
    end

    assign o_push = accept && (written || row_end);

    always_comb begin
        o_job.pend      = pend;
        o_job.end_empty = !(r_any || written);
        o_job.skip      = r_skip;
        o_job.mask      = mask;
        o_job.note      = i_row.note;
        o_job.inst      = i_row.instrument;
        o_job.vol       = i_row.volume;
        o_job.code      = code;
        o_job.arg       = arg;
    end

    always_comb begin
        n_skip = r_skip;
        n_row  = r_row;
        n_any  = r_any;
        if (accept) begin
            n_skip = written ? '0 : r_skip + 1'b1;
            n_any  = r_any || written;
            n_row  = r_row + 1'b1;
            if (row_end) begin
                n_skip = '0;
                n_any  = 1'b0;
                n_row  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_note <= '0;
            r_empty_fx   <= '0;
            r_skip       <= '0;
            r_row        <= '0;
            r_any        <= 1'b0;
        end else begin
            r_skip <= n_skip;
            r_row  <= n_row;
            r_any  <= n_any;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EMPTY_NOTE:   r_empty_note <= i_cfg_data;
                    CFG_EMPTY_EFFECT: r_empty_fx   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: rtl/srce_queue.sv
// Small register queue of classified rows between front and back.
module srce_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srce_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output srce_pkg::t_job o_job
);
    import srce_pkg::*;

    localparam int QA_W = $clog2(QUEUE_DEPTH);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wp, r_rp;
    logic [QA_W:0]     r_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == (QA_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: rtl/srce_back.sv
// Back end: walks the present slots of a row, one output word per cycle while the output is not stalled.
module srce_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  srce_pkg::t_job i_q_job,
    output logic           o_q_pop,
    srce_res_if.source     o_res
);
    import srce_pkg::*;

    t_job               r_job;
    t_pend              r_pend, n_pend;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_ov;
    logic [1:0]         r_kind;
    logic [BYTE_W-1:0]  r_byte;
    logic [COUNT_W-1:0] r_bcnt;
    logic               r_last;

    logic               emit, load;
    t_pend              rest;
    logic [SLOT_W-1:0]  slot, fx_off;
    logic [BYTE_W-1:0]  sel_byte;

    assign emit    = (r_pend != '0) && (!r_ov || o_res.ready);
    assign rest    = r_pend & (r_pend - 1'b1);
    assign load    = (r_pend == '0) || (emit && rest == '0);
    assign o_q_pop = load && i_q_valid;

    // lowest pending slot
    always_comb begin
        slot = SLOT_END;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_pend[s]) slot = SLOT_W'(s);
        end
    end

    assign fx_off = slot - SLOT_FX0;

    always_comb begin
        case (slot)
            SLOT_SKIP: sel_byte = r_job.skip;
            SLOT_MASK: sel_byte = r_job.mask;
            SLOT_NOTE: sel_byte = r_job.note;
            SLOT_INST: sel_byte = r_job.inst;
            SLOT_VOL:  sel_byte = r_job.vol;
            SLOT_END:  sel_byte = '0;
            default:   sel_byte = fx_off[0] ? r_job.arg[fx_off[2:1]]
                                            : r_job.code[fx_off[2:1]];
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        if (load) n_pend = i_q_valid ? i_q_job.pend : '0;
        else if (emit) n_pend = rest;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_job <= i_q_job;
        if (emit) begin
            r_last <= (rest == '0);
            if (slot == SLOT_END) begin
                r_kind <= r_job.end_empty ? KIND_EMPTY : KIND_END;
                r_byte <= '0;
                r_bcnt <= r_job.end_empty ? '0 : r_cnt;
            end else begin
                r_kind <= KIND_BYTE;
                r_byte <= sel_byte;
                r_bcnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (emit) begin
                r_ov  <= 1'b1;
                r_cnt <= (slot == SLOT_END) ? '0 : r_cnt + 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.item_kind   = r_kind;
    assign o_res.out_byte    = r_byte;
    assign o_res.byte_count  = r_bcnt;
    assign o_res.last_of_row = r_last;
endmodule

// File: rtl/sparse_row_cell_encoder_core.sv
// Top level of the sparse row cell encoder: front, row queue and back end.
//
// Usage:
//  - i_row carries one pattern row per word (note, instrument, volume and
//    four effect code/argument pairs); a word moves when valid and ready.
//  - o_res carries encoded words: payload bytes (skip count, presence mask,
//    present fields) and, after the last row of a phrase, one end word with
//    the phrase byte count or an empty-phrase mark. last_of_row flags the
//    final word caused by a row.
//  - The config port (i_cfg_we/i_cfg_idx/i_cfg_data) sets the empty note
//    code (index 0) and the empty effect code (index 1); write while idle.
//  - Throughput: the back end sends one word per cycle while o_res does not
//    stall; a row yields one word per present slot (3 to 13, plus 1 on a
//    phrase end), and rows with nothing present yield none, one if they
//    close a phrase. The front takes a row every cycle while the four-entry
//    row queue has room. With the queue empty, the first word of a row
//    passes the queue, the back end load and then the output register.
//  - Reset clears config, counters, the queue and the output register.
//  - When o_res stalls the output register holds its word, the back end
//    waits, and i_row ready drops once the queue is full.
module sparse_row_cell_encoder_core #(
    parameter int PHRASE_ROWS = srce_pkg::DEF_PHRASE_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [srce_pkg::BYTE_W-1:0]    i_cfg_data,
    srce_row_if.sink                       i_row,
    srce_res_if.source                     o_res
);
    import srce_pkg::*;

    logic push, full, pop, q_valid;
    t_job push_job, head_job;

    srce_front #(
        .PHRASE_ROWS (PHRASE_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_row      (i_row),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    srce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    srce_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_q_pop   (pop),
        .o_res     (o_res)
    );
endmodule
